// ===== design/kmp_pkg.sv =====
package kmp_pkg;

    // Sizes of the pattern stores and of the symbol and position fields
    localparam int MAX_PATTERN   = 64;
    localparam int ELEMENT_BITS  = 8;
    localparam int POSITION_BITS = 32;
    localparam int START_BITS    = 32;

    // Index into the stores and count of symbols (0 .. MAX_PATTERN)
    localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

    // Request kinds on the func field
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_FALL
    } kmp_state_t;

endpackage

// ===== design/kmp_ram.sv =====
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/kmp_stream_matcher.sv =====
// Streaming Knuth-Morris-Pratt matcher.
// Input channel (in_valid / in_stall): one request carries func, element and
// first. func = 0 appends a pattern symbol (first = 1 starts a new pattern and
// clears the text state); func = 1 feeds a text symbol (first = 1 restarts the
// text index at zero). Symbols past the pattern capacity are dropped.
// Output channel (out_valid / out_stall): one request per full match, giving
// the text index where the match begins; overlapping matches are reported.
// One request is worked on at a time. A pattern symbol that is the first one or
// is dropped, and a text symbol with an empty pattern, are finished in ST_IDLE;
// other symbols go on to ST_WAIT, which falls back through the prefix table one
// step per registered read, as each store has a single read port. After a full
// match, ST_FALL uses the table entry read for the fallback and then loads the
// match into the output register once that register is free.
// Reset clears all counters and the output valid flag; the stores are not
// cleared, and only values read from entries already written are used.
// A stalled output holds its result; the block then waits before loading the
// next match but keeps taking requests until a new match must be shown.
module kmp_stream_matcher
    import kmp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [ELEMENT_BITS-1:0] element,
    input  logic                    first,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [START_BITS-1:0]   match_start
);

    kmp_state_t state_reg, state_next;
    logic [IDX_BITS-1:0]      cur_reg, cur_next;
    logic [LEN_BITS-1:0]      len_reg, len_next;
    logic [LEN_BITS-1:0]      build_reg, build_next;
    logic [LEN_BITS-1:0]      matched_reg, matched_next;
    logic [POSITION_BITS-1:0] tpos_reg, tpos_next;
    logic                     func_reg, func_next;
    logic [ELEMENT_BITS-1:0]  sym_reg, sym_next;
    logic                     out_valid_reg, out_valid_next;
    logic [START_BITS-1:0]    match_start_reg, match_start_next;

    // Store ports
    logic                    wr_en;
    logic [IDX_BITS-1:0]     wr_addr;
    logic [ELEMENT_BITS-1:0] pat_wr_data;
    logic [LEN_BITS-1:0]     pf_wr_data;
    logic [IDX_BITS-1:0]     pat_rd_addr;
    logic [IDX_BITS-1:0]     pf_rd_addr;
    logic [ELEMENT_BITS-1:0] pat_q;
    logic [LEN_BITS-1:0]     pf_q;

    logic                     hit;
    logic [LEN_BITS-1:0]      step_len;
    logic [POSITION_BITS-1:0] start_full;

    kmp_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pat_wr_data),
        .rd_addr (pat_rd_addr),
        .rd_data (pat_q)
    );

    kmp_ram #(
        .WIDTH (LEN_BITS),
        .DEPTH (MAX_PATTERN)
    ) u_prefix_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pf_wr_data),
        .rd_addr (pf_rd_addr),
        .rd_data (pf_q)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign match_start = match_start_reg;

    assign hit        = (sym_reg == pat_q);
    assign step_len   = LEN_BITS'(cur_reg) + LEN_BITS'(hit);
    assign start_full = tpos_reg + POSITION_BITS'(1) - POSITION_BITS'(len_reg);

    // State and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            len_reg       <= '0;
            build_reg     <= '0;
            matched_reg   <= '0;
            tpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            len_reg       <= len_next;
            build_reg     <= build_next;
            matched_reg   <= matched_next;
            tpos_reg      <= tpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        sym_reg         <= sym_next;
        match_start_reg <= match_start_next;
    end

    // Next state, store accesses and output
    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        len_next         = len_reg;
        build_next       = build_reg;
        matched_next     = matched_reg;
        tpos_next        = tpos_reg;
        func_next        = func_reg;
        sym_next         = sym_reg;
        match_start_next = match_start_reg;
        out_valid_next   = out_valid_reg && out_stall;
        wr_en            = 1'b0;
        wr_addr          = IDX_BITS'(len_reg);
        pat_wr_data      = sym_reg;
        pf_wr_data       = step_len;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    sym_next  = element;
                    if (func == FUNC_PATTERN)
                    begin
                        // Start a new pattern at element 0
                        if (first || len_reg == '0)
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = '0;
                            pat_wr_data  = element;
                            pf_wr_data   = '0;
                            len_next     = LEN_BITS'(1);
                            build_next   = '0;
                            if (first)
                            begin
                                matched_next = '0;
                                tpos_next    = '0;
                            end
                        end
                        // Extend the table unless the pattern is full
                        else if (len_reg < LEN_BITS'(MAX_PATTERN))
                        begin
                            cur_next   = IDX_BITS'(build_reg);
                            state_next = ST_WAIT;
                        end
                    end
                    else
                    begin
                        if (first)
                        begin
                            matched_next = '0;
                            tpos_next    = '0;
                        end
                        if (len_reg == '0)
                        begin
                            // Empty pattern: advance the index only
                            tpos_next = (first ? '0 : tpos_reg) + POSITION_BITS'(1);
                        end
                        else
                        begin
                            cur_next   = first ? '0 : IDX_BITS'(matched_reg);
                            state_next = ST_WAIT;
                        end
                    end
                end
            end

            ST_WAIT:
            begin
                if (!hit && cur_reg != '0)
                begin
                    // Fall back one step through the prefix table
                    cur_next = IDX_BITS'(pf_q);
                end
                else if (func_reg == FUNC_PATTERN)
                begin
                    // Store the symbol and its prefix length
                    wr_en      = 1'b1;
                    build_next = step_len;
                    len_next   = len_reg + LEN_BITS'(1);
                    state_next = ST_IDLE;
                end
                else if (step_len >= len_reg)
                begin
                    // Full match: read the fallback entry for the last element
                    matched_next = step_len;
                    state_next   = ST_FALL;
                end
                else
                begin
                    matched_next = step_len;
                    tpos_next    = tpos_reg + POSITION_BITS'(1);
                    state_next   = ST_IDLE;
                end
            end

            ST_FALL:
            begin
                // Load the match once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    match_start_next = START_BITS'(start_full);
                    matched_next     = pf_q;
                    tpos_next        = tpos_reg + POSITION_BITS'(1);
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Read addresses for the data seen next cycle
        pat_rd_addr = cur_next;
        if (state_next == ST_FALL)
        begin
            pf_rd_addr = IDX_BITS'(len_reg - LEN_BITS'(1));
        end
        else
        begin
            pf_rd_addr = cur_next - IDX_BITS'(1);
        end
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kmp_pkg::*;

    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_CYCLES  = 300;

    // How a directed row is checked
    typedef enum logic [1:0] {
        FROM_MODEL,
        NO_MATCH,
        MATCH_AT
    } check_kind_t;

    typedef struct packed {
        logic                    f;
        logic [ELEMENT_BITS-1:0] el;
        logic                    fst;
        check_kind_t             how;
        logic [START_BITS-1:0]   want;
    } plan_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    func = FUNC_PATTERN;
    logic [ELEMENT_BITS-1:0] element = '0;
    logic                    first = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [START_BITS-1:0]   match_start;

    // Matcher state mirrored on the testbench side
    logic [ELEMENT_BITS-1:0] pat_sym [MAX_PATTERN] = '{default: '0};
    logic [LEN_BITS-1:0]     fail_len [MAX_PATTERN] = '{default: '0};
    logic [LEN_BITS-1:0]     pat_len = '0;
    logic [LEN_BITS-1:0]     build_len = '0;
    logic [LEN_BITS-1:0]     hit_len = '0;
    logic [POSITION_BITS-1:0] text_idx = '0;

    logic [START_BITS-1:0]   starts_due [$];
    int                      errors = 0;
    int                      live_items = 0;
    int                      hold_req = 0;
    bit                      send_calm = 1'b0;
    bit                      take_calm = 1'b0;

    // Directed requests: empty pattern, overlap, growth, new text, symbol extremes
    plan_row_t plan [24] = '{
        '{FUNC_TEXT,    8'h00, 1'b1, NO_MATCH,   32'd0},
        '{FUNC_TEXT,    8'hFF, 1'b0, NO_MATCH,   32'd0},
        '{FUNC_PATTERN, 8'hAA, 1'b1, NO_MATCH,   32'd0},
        '{FUNC_PATTERN, 8'hAA, 1'b0, NO_MATCH,   32'd0},
        '{FUNC_TEXT,    8'hAA, 1'b1, NO_MATCH,   32'd0},
        '{FUNC_TEXT,    8'hAA, 1'b0, MATCH_AT,   32'd0},
        '{FUNC_TEXT,    8'hAA, 1'b0, MATCH_AT,   32'd1},
        '{FUNC_TEXT,    8'h55, 1'b0, NO_MATCH,   32'd0},
        '{FUNC_PATTERN, 8'h55, 1'b0, NO_MATCH,   32'd0},
        '{FUNC_TEXT,    8'hAA, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'hAA, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'h55, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_PATTERN, 8'h00, 1'b1, NO_MATCH,   32'd0},
        '{FUNC_PATTERN, 8'hFF, 1'b0, NO_MATCH,   32'd0},
        '{FUNC_PATTERN, 8'h00, 1'b0, NO_MATCH,   32'd0},
        '{FUNC_TEXT,    8'h00, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'hFF, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'hFF, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'hFF, 1'b1, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'hFF, 1'b0, FROM_MODEL, 32'd0},
        '{FUNC_TEXT,    8'h00, 1'b0, FROM_MODEL, 32'd0}
    };

    kmp_stream_matcher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .element     (element),
        .first       (first),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_start (match_start)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Extend the pattern and its failure table by one symbol
    function automatic void learn_symbol(input logic [ELEMENT_BITS-1:0] s, input logic fst);
        if (fst)
        begin
            pat_len   = '0;
            build_len = '0;
            hit_len   = '0;
            text_idx  = '0;
        end
        if (pat_len >= MAX_PATTERN)
            return;
        pat_sym[pat_len] = s;
        if (pat_len == 0)
        begin
            build_len   = '0;
            fail_len[0] = '0;
        end
        else
        begin
            while (build_len > 0 && s != pat_sym[build_len])
                build_len = fail_len[build_len - 1];
            if (s == pat_sym[build_len])
                build_len = build_len + 1'b1;
            fail_len[pat_len] = build_len;
        end
        pat_len = pat_len + 1'b1;
    endfunction

    // Advance the match over one text symbol; return 1 on a full match
    function automatic bit scan_symbol(input logic [ELEMENT_BITS-1:0] s, input logic fst,
                                       output logic [START_BITS-1:0] start);
        bit hit;
        hit   = 1'b0;
        start = '0;
        if (fst)
        begin
            hit_len  = '0;
            text_idx = '0;
        end
        if (pat_len > 0)
        begin
            while (hit_len > 0 && s != pat_sym[hit_len])
                hit_len = fail_len[hit_len - 1];
            if (s == pat_sym[hit_len])
                hit_len = hit_len + 1'b1;
            if (hit_len >= pat_len)
            begin
                start   = START_BITS'(text_idx + 1'b1 - POSITION_BITS'(pat_len));
                hit     = 1'b1;
                hit_len = fail_len[pat_len - 1];
            end
        end
        text_idx = text_idx + 1'b1;
        return hit;
    endfunction

    function automatic int pick_wait(input bit calm);
        if (calm)
            return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 2);
    endfunction

    task automatic flag_error(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        errors++;
    endtask

    // Offer one request after a random gap, hold it until taken, then predict
    task automatic offer(input logic f, input logic [ELEMENT_BITS-1:0] el, input logic fst,
                         input check_kind_t how, input logic [START_BITS-1:0] want);
        int                    gap;
        bit                    ignored;
        bit                    hit;
        logic [START_BITS-1:0] start;
        gap = pick_wait(send_calm);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        element  <= el;
        first    <= fst;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        ignored = (f == FUNC_PATTERN) && !fst && (pat_len >= MAX_PATTERN);
        if (!ignored)
            live_items++;
        hit = 1'b0;
        start = '0;
        if (f == FUNC_PATTERN)
            learn_symbol(el, fst);
        else
            hit = scan_symbol(el, fst, start);
        if (how == MATCH_AT)
            starts_due = {starts_due, want};
        else if (how == FROM_MODEL && hit)
            starts_due = {starts_due, start};
    endtask

    // Take matches with random hold-offs and check each against the oldest due
    initial
    begin
        int                    wait_left;
        logic [START_BITS-1:0] due;
        wait_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (starts_due.size() == 0)
                    flag_error($sformatf("match at %0d with none pending", match_start));
                else
                begin
                    due = starts_due.pop_front();
                    if (match_start !== due)
                        flag_error($sformatf("match_start %0d, want %0d", match_start, due));
                end
                wait_left = pick_wait(take_calm);
            end
            if (hold_req > 0)
            begin
                wait_left = hold_req;
                hold_req  = 0;
            end
            out_stall <= (wait_left > 0);
            if (wait_left > 0)
                wait_left--;
        end
    end

    // Drive reset, the directed plan, then random pattern and text streams
    initial
    begin
        logic [ELEMENT_BITS-1:0] abc [3];
        logic [ELEMENT_BITS-1:0] motif [$];
        logic [ELEMENT_BITS-1:0] sym;
        int                      abc_size;
        int                      plen;
        int                      tlen;
        int                      cut;
        int                      pick;
        int                      squeezes;
        bit                      new_text;
        squeezes = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer(plan[i].f, plan[i].el, plan[i].fst, plan[i].how, plan[i].want);

        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            take_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if ((pick == 9 || squeezes == 0) && squeezes < 2)
            begin
                // One-symbol pattern, every text symbol matches; receiver holds off
                squeezes++;
                send_calm = 1'b1;
                sym = ELEMENT_BITS'($urandom);
                offer(FUNC_PATTERN, sym, 1'b1, FROM_MODEL, '0);
                hold_req = HOLD_CYCLES;
                repeat (40)
                    offer(FUNC_TEXT, sym, 1'b0, FROM_MODEL, '0);
            end
            else if (pick >= 7)
            begin
                // Noise: any func, any symbol, sporadic restarts
                repeat ($urandom_range(5, 15))
                    offer(1'($urandom_range(0, 1)), ELEMENT_BITS'($urandom),
                          ($urandom_range(0, 3) == 0), FROM_MODEL, '0);
            end
            else
            begin
                // Pattern from a small alphabet, then text seeded with copies of it
                abc_size = $urandom_range(1, 3);
                for (int k = 0; k < abc_size; k++)
                    abc[k] = ELEMENT_BITS'($urandom);
                plen = ($urandom_range(0, 7) == 0) ?
                       $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 6) : $urandom_range(1, 6);
                motif.delete();
                for (int k = 0; k < plen; k++)
                begin
                    motif = {motif, abc[$urandom_range(0, abc_size - 1)]};
                    offer(FUNC_PATTERN, motif[k], (k == 0) && ($urandom_range(0, 7) != 0),
                          FROM_MODEL, '0);
                end
                tlen = (plen > 8) ? $urandom_range(2, 5) : $urandom_range(10, 40);
                new_text = ($urandom_range(0, 3) != 0);
                for (int k = 0; k < tlen; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        offer(FUNC_PATTERN, abc[$urandom_range(0, abc_size - 1)], 1'b0,
                              FROM_MODEL, '0);
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        cut = ($urandom_range(0, 2) == 0) ?
                              $urandom_range(1, motif.size()) : motif.size();
                        for (int j = 0; j < cut; j++)
                            offer(FUNC_TEXT, motif[j], (k == 0) && (j == 0) && new_text,
                                  FROM_MODEL, '0);
                    end
                    else if ($urandom_range(0, 9) == 0)
                        offer(FUNC_TEXT, ELEMENT_BITS'($urandom), (k == 0) && new_text,
                              FROM_MODEL, '0);
                    else
                        offer(FUNC_TEXT, abc[$urandom_range(0, abc_size - 1)],
                              (k == 0) && new_text, FROM_MODEL, '0);
                end
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding matches, then let the block settle
        while (starts_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
